FILE: design/rsb4_pkg.sv
// Package for the base-4 key vector radix sorter.
// Holds sizes, payload types, the sequencer states and the bucket control struct.
// No dependencies; every other design file but rsb4_ram imports it.
package rsb4_pkg;

    // Sizes of the vector stores and the key.
    localparam int MAX_VECTORS = 64;
    localparam int KEY_DIGITS  = 10;
    localparam int NUM_DIGITS  = 10;
    localparam int NUM_BUCKETS = 4;
    localparam int DIGIT_W     = 2;
    localparam int VEC_W       = NUM_DIGITS * DIGIT_W;
    localparam int ADDR_W      = $clog2(MAX_VECTORS);
    localparam int CNT_W       = $clog2(MAX_VECTORS + 1);
    localparam int POS_W       = $clog2(NUM_DIGITS);

    // Input item: one key vector and the end-of-set flag.
    typedef struct packed {
        logic [DIGIT_W-1:0] key_digit_0;
        logic [DIGIT_W-1:0] key_digit_1;
        logic [DIGIT_W-1:0] key_digit_2;
        logic [DIGIT_W-1:0] key_digit_3;
        logic [DIGIT_W-1:0] key_digit_4;
        logic [DIGIT_W-1:0] key_digit_5;
        logic [DIGIT_W-1:0] key_digit_6;
        logic [DIGIT_W-1:0] key_digit_7;
        logic [DIGIT_W-1:0] key_digit_8;
        logic [DIGIT_W-1:0] key_digit_9;
        logic               last_of_set;
    } t_in_item;

    // Output item: one sorted vector and its status flags.
    typedef struct packed {
        logic [DIGIT_W-1:0] sorted_digit_0;
        logic [DIGIT_W-1:0] sorted_digit_1;
        logic [DIGIT_W-1:0] sorted_digit_2;
        logic [DIGIT_W-1:0] sorted_digit_3;
        logic [DIGIT_W-1:0] sorted_digit_4;
        logic [DIGIT_W-1:0] sorted_digit_5;
        logic [DIGIT_W-1:0] sorted_digit_6;
        logic [DIGIT_W-1:0] sorted_digit_7;
        logic [DIGIT_W-1:0] sorted_digit_8;
        logic [DIGIT_W-1:0] sorted_digit_9;
        logic               last_of_output;
        logic               items_dropped;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_CNT,
        S_PFX,
        S_PLC,
        S_NEXT,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

    // Commands from the sequencer to the bucket counter unit.
    typedef struct packed {
        logic               clear;
        logic               incr;
        logic               prefix;
        logic               place;
        logic [DIGIT_W-1:0] digit;
    } t_bkt_ctl;

endpackage

FILE: design/rsb4_ifs.sv
// Valid/ready channel interfaces for the radix sorter input and output items.
// Depends on rsb4_pkg for the payload types.
interface rsb4_in_if import rsb4_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface rsb4_out_if import rsb4_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: design/rsb4_ram.sv
// Generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and appears in the cycle after the read request.
module rsb4_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

FILE: design/rsb4_bucket.sv
// Bucket counter unit: counts digits, forms running bucket ends and hands out
// placement slots for one counting pass. Depends on rsb4_pkg.
module rsb4_bucket import rsb4_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bkt_ctl          i_ctl,
    output logic [ADDR_W-1:0] o_slot
);

    logic [CNT_W-1:0] r_cnt [NUM_BUCKETS];
    logic [CNT_W-1:0] n_cnt [NUM_BUCKETS];
    logic [CNT_W-1:0] slot_full;

    // The slot for a placement is the bucket end minus one.
    assign slot_full = r_cnt[i_ctl.digit] - CNT_W'(1);
    assign o_slot    = slot_full[ADDR_W-1:0];

    // Next counts: clear, count, prefix sum or placement decrement.
    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clear) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                n_cnt[b] = '0;
            end
        end else if (i_ctl.incr) begin
            n_cnt[i_ctl.digit] = r_cnt[i_ctl.digit] + CNT_W'(1);
        end else if (i_ctl.prefix) begin
            n_cnt[1] = r_cnt[1] + r_cnt[0];
            n_cnt[2] = r_cnt[2] + r_cnt[1] + r_cnt[0];
            n_cnt[3] = r_cnt[3] + r_cnt[2] + r_cnt[1] + r_cnt[0];
        end else if (i_ctl.place) begin
            n_cnt[i_ctl.digit] = slot_full;
        end
    end

    // Count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_cnt[b] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/radix_sort_base4_vectors_core.sv
// Top level of the base-4 key vector radix sorter: sequencer, two vector stores
// and the output register. Depends on rsb4_pkg, rsb4_ifs, rsb4_ram, rsb4_bucket.
//
//  Channel   Dir  Modport  Carries
//  i_in      in   sink     key_digit_0..9, last_of_set
//  o_out     out  source   sorted_digit_0..9, last_of_output, items_dropped
//
// An input item is taken whenever it is valid while the block is loading a set.
// After the flagged item, each of the ten digit passes over the n stored vectors
// runs a read sweep to count, a prefix step, a read sweep to place and a step to
// swap stores; each store has a single read port, so a sweep reads one vector at a time.
// Results then leave one by one through the output register; a stalling sink holds back the next read.
// Reset is synchronous and clears control only; the stores need no clearing pass.
module radix_sort_base4_vectors_core import rsb4_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsb4_in_if.sink      i_in,
    rsb4_out_if.source   o_out
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_src_b, n_src_b;
    logic              r_dropped, n_dropped;
    logic              r_dv;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              rd_en;
    logic              sort_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic              load_out;
    logic              out_last;
    logic              in_acc;
    logic              full;
    logic              place;
    t_bkt_ctl          bkt_ctl;
    logic [ADDR_W-1:0] slot;
    logic [VEC_W-1:0]  in_vec;
    logic [VEC_W-1:0]  rdata_a, rdata_b, src_data;
    logic              wr_a_en, wr_b_en;
    logic [ADDR_W-1:0] wr_a_addr;
    logic [VEC_W-1:0]  wr_a_data;

    // Pack the input digits, digit i at bits 2i+1..2i.
    assign in_vec = {i_in.item.key_digit_9, i_in.item.key_digit_8, i_in.item.key_digit_7,
                     i_in.item.key_digit_6, i_in.item.key_digit_5, i_in.item.key_digit_4,
                     i_in.item.key_digit_3, i_in.item.key_digit_2, i_in.item.key_digit_1,
                     i_in.item.key_digit_0};

    assign i_in.ready = (r_state == S_LOAD);
    assign in_acc     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(MAX_VECTORS));
    assign src_data   = r_src_b ? rdata_b : rdata_a;
    assign out_last   = ((r_idx + CNT_W'(1)) == r_count);
    assign place      = r_dv && (r_state == S_PLC);

    // Sequencer: next state, counters and memory requests.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_pos     = r_pos;
        n_src_b   = r_src_b;
        n_dropped = r_dropped;
        rd_en     = 1'b0;
        sort_rd   = 1'b0;
        rd_addr   = r_idx[ADDR_W-1:0];
        load_out  = 1'b0;
        bkt_ctl   = '0;
        bkt_ctl.digit = src_data[2*r_pos +: DIGIT_W];
        bkt_ctl.incr  = r_dv && (r_state == S_CNT);
        bkt_ctl.place = place;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in.item.last_of_set) begin
                        n_state       = S_CNT;
                        n_idx         = '0;
                        n_pos         = POS_W'(KEY_DIGITS - 1);
                        n_src_b       = 1'b0;
                        bkt_ctl.clear = 1'b1;
                    end
                end
            end
            S_CNT: begin
                if (r_idx != r_count) begin
                    rd_en   = 1'b1;
                    sort_rd = 1'b1;
                    n_idx   = r_idx + CNT_W'(1);
                end else begin
                    n_state = S_PFX;
                end
            end
            S_PFX: begin
                bkt_ctl.prefix = 1'b1;
                n_idx          = r_count;
                n_state        = S_PLC;
            end
            S_PLC: begin
                // Placement walks the source from the end to keep the pass stable.
                if (r_idx != '0) begin
                    rd_en   = 1'b1;
                    sort_rd = 1'b1;
                    n_idx   = r_idx - CNT_W'(1);
                    rd_addr = n_idx[ADDR_W-1:0];
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_src_b       = !r_src_b;
                bkt_ctl.clear = 1'b1;
                n_idx         = '0;
                if (r_pos == '0) begin
                    n_state = S_OUT_RD;
                end else begin
                    n_pos   = r_pos - POS_W'(1);
                    n_state = S_CNT;
                end
            end
            S_OUT_RD: begin
                if (!r_out_valid || o_out.ready) begin
                    rd_en   = 1'b1;
                    n_state = S_OUT_WR;
                end
            end
            S_OUT_WR: begin
                load_out = 1'b1;
                n_idx    = r_idx + CNT_W'(1);
                if (out_last) begin
                    n_state   = S_LOAD;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_idx     <= '0;
            r_count   <= '0;
            r_pos     <= '0;
            r_src_b   <= 1'b0;
            r_dropped <= 1'b0;
            r_dv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_src_b   <= n_src_b;
            r_dropped <= n_dropped;
            r_dv      <= sort_rd;
        end
    end

    // Store A takes loaded vectors and placements of passes that read B; B those of passes that read A.
    assign wr_a_en   = (in_acc && !full) || (place && r_src_b);
    assign wr_a_addr = (r_state == S_LOAD) ? r_count[ADDR_W-1:0] : slot;
    assign wr_a_data = (r_state == S_LOAD) ? in_vec : src_data;
    assign wr_b_en   = place && !r_src_b;

    rsb4_ram #(
        .DEPTH (MAX_VECTORS),
        .WIDTH (VEC_W)
    ) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a_en),
        .i_wr_addr (wr_a_addr),
        .i_wr_data (wr_a_data),
        .i_rd_en   (rd_en && !r_src_b),
        .i_rd_addr (rd_addr),
        .o_rd_data (rdata_a)
    );

    rsb4_ram #(
        .DEPTH (MAX_VECTORS),
        .WIDTH (VEC_W)
    ) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b_en),
        .i_wr_addr (slot),
        .i_wr_data (src_data),
        .i_rd_en   (rd_en && r_src_b),
        .i_rd_addr (rd_addr),
        .o_rd_data (rdata_b)
    );

    // Bucket counts and placement slots.
    rsb4_bucket u_bucket (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (bkt_ctl),
        .o_slot  (slot)
    );

    // Output register: holds one result item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_item.sorted_digit_0 <= src_data[1:0];
            r_out_item.sorted_digit_1 <= src_data[3:2];
            r_out_item.sorted_digit_2 <= src_data[5:4];
            r_out_item.sorted_digit_3 <= src_data[7:6];
            r_out_item.sorted_digit_4 <= src_data[9:8];
            r_out_item.sorted_digit_5 <= src_data[11:10];
            r_out_item.sorted_digit_6 <= src_data[13:12];
            r_out_item.sorted_digit_7 <= src_data[15:14];
            r_out_item.sorted_digit_8 <= src_data[17:16];
            r_out_item.sorted_digit_9 <= src_data[19:18];
            r_out_item.last_of_output <= out_last;
            r_out_item.items_dropped  <= r_dropped;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the base-4 key vector radix sorter.
// Depends on rsb4_pkg, the rsb4_in_if/rsb4_out_if channels and radix_sort_base4_vectors_core.
// A scoreboard class predicts each sorted set; tasks feed the input, a process drives ready.
module tb_top;
    import rsb4_pkg::*;

    // One key vector: element i is digit i, element 0 the most significant.
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_key_vec;

    localparam int ITEM_TARGET = 350;
    localparam int QUIET_ITEMS = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 300000;

    // Collects each set of vectors, sorts it and checks the block's results in order.
    class sorted_set_tracker;
        t_key_vec  open_set[$];
        bit        open_dropped;
        t_out_item sorted_vectors_due[$];
        int        errors;
        int        results_checked;
        int        sets_sorted;
        int        overflow_sets;

        // Stores one accepted vector and sorts the set when the flagged one arrives.
        function void take_key_vector(t_in_item it);
            t_key_vec v;
            v[0] = it.key_digit_0;
            v[1] = it.key_digit_1;
            v[2] = it.key_digit_2;
            v[3] = it.key_digit_3;
            v[4] = it.key_digit_4;
            v[5] = it.key_digit_5;
            v[6] = it.key_digit_6;
            v[7] = it.key_digit_7;
            v[8] = it.key_digit_8;
            v[9] = it.key_digit_9;
            if (open_set.size() < MAX_VECTORS) begin
                open_set.push_back(v);
            end else begin
                open_dropped = 1'b1;
            end
            if (it.last_of_set) begin
                radix_sort_open_set();
            end
        endfunction

        // Stable counting passes from the least significant key digit up to digit 0.
        function void radix_sort_open_set();
            t_key_vec  src[$];
            t_key_vec  dst[MAX_VECTORS];
            int        bucket_cnt[NUM_BUCKETS];
            int        n;
            int        d;
            t_out_item o;
            src = open_set;
            n = src.size();
            for (int pos = KEY_DIGITS - 1; pos >= 0; pos--) begin
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    bucket_cnt[b] = 0;
                end
                for (int i = 0; i < n; i++) begin
                    bucket_cnt[src[i][pos]]++;
                end
                for (int b = 1; b < NUM_BUCKETS; b++) begin
                    bucket_cnt[b] += bucket_cnt[b-1];
                end
                // Walking backward keeps equal digits in arrival order.
                for (int i = n - 1; i >= 0; i--) begin
                    d = int'(src[i][pos]);
                    bucket_cnt[d]--;
                    dst[bucket_cnt[d]] = src[i];
                end
                for (int i = 0; i < n; i++) begin
                    src[i] = dst[i];
                end
            end
            for (int k = 0; k < n; k++) begin
                o.sorted_digit_0 = src[k][0];
                o.sorted_digit_1 = src[k][1];
                o.sorted_digit_2 = src[k][2];
                o.sorted_digit_3 = src[k][3];
                o.sorted_digit_4 = src[k][4];
                o.sorted_digit_5 = src[k][5];
                o.sorted_digit_6 = src[k][6];
                o.sorted_digit_7 = src[k][7];
                o.sorted_digit_8 = src[k][8];
                o.sorted_digit_9 = src[k][9];
                o.last_of_output = (k == n - 1);
                o.items_dropped  = open_dropped;
                sorted_vectors_due.push_back(o);
            end
            sets_sorted++;
            if (open_dropped) begin
                overflow_sets++;
            end
            open_set.delete();
            open_dropped = 1'b0;
        endfunction

        function void check_field(string name, logic [DIGIT_W-1:0] exp_v,
                                  logic [DIGIT_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compares one result from the block with the oldest predicted vector.
        function void check_sorted_vector(t_out_item got);
            t_out_item exp_o;
            if (sorted_vectors_due.size() == 0) begin
                $error("sorted vector arrived with none predicted: %h", got);
                errors++;
                return;
            end
            exp_o = sorted_vectors_due.pop_front();
            results_checked++;
            check_field("sorted_digit_0", exp_o.sorted_digit_0, got.sorted_digit_0);
            check_field("sorted_digit_1", exp_o.sorted_digit_1, got.sorted_digit_1);
            check_field("sorted_digit_2", exp_o.sorted_digit_2, got.sorted_digit_2);
            check_field("sorted_digit_3", exp_o.sorted_digit_3, got.sorted_digit_3);
            check_field("sorted_digit_4", exp_o.sorted_digit_4, got.sorted_digit_4);
            check_field("sorted_digit_5", exp_o.sorted_digit_5, got.sorted_digit_5);
            check_field("sorted_digit_6", exp_o.sorted_digit_6, got.sorted_digit_6);
            check_field("sorted_digit_7", exp_o.sorted_digit_7, got.sorted_digit_7);
            check_field("sorted_digit_8", exp_o.sorted_digit_8, got.sorted_digit_8);
            check_field("sorted_digit_9", exp_o.sorted_digit_9, got.sorted_digit_9);
            check_field("last_of_output", exp_o.last_of_output, got.last_of_output);
            check_field("items_dropped", exp_o.items_dropped, got.items_dropped);
        endfunction

        function bit all_delivered();
            return (sorted_vectors_due.size() == 0) && (open_set.size() == 0);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rsb4_in_if  in_ch ();
    rsb4_out_if out_ch ();

    radix_sort_base4_vectors_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sorted_set_tracker tracker = new();

    int cycle_count   = 0;
    int items_sent    = 0;
    int hold_requests = 0;
    bit quiet         = 1'b0;
    bit send_bursts   = 1'b0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result sink: random stall bursts, quiet stretches and the long hold-off on request.
    initial begin : result_sink
        int stall_left   = 0;
        int hold_left    = 0;
        int hold_served  = 0;
        int stretch_left = 0;
        bit bursts_on    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (stretch_left == 0) begin
                bursts_on = ($urandom_range(0, 2) != 0);
                stretch_left = $urandom_range(50, 200);
            end else begin
                stretch_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && bursts_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted result is checked at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tracker.check_sorted_vector(out_ch.item);
        end
    end

    function automatic t_in_item to_item(t_key_vec v, bit last);
        t_in_item it;
        it.key_digit_0 = v[0];
        it.key_digit_1 = v[1];
        it.key_digit_2 = v[2];
        it.key_digit_3 = v[3];
        it.key_digit_4 = v[4];
        it.key_digit_5 = v[5];
        it.key_digit_6 = v[6];
        it.key_digit_7 = v[7];
        it.key_digit_8 = v[8];
        it.key_digit_9 = v[9];
        it.last_of_set = last;
        return it;
    endfunction

    // Random vector: full range, a two-digit alphabet for ties, or a near copy of the last one.
    function automatic t_key_vec rand_vector(t_key_vec prev);
        t_key_vec v;
        int       mode;
        mode = $urandom_range(0, 2);
        v = prev;
        if (mode == 0) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                v[i] = DIGIT_W'($urandom_range(0, 3));
            end
        end else if (mode == 1) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                v[i] = DIGIT_W'($urandom_range(0, 1));
            end
        end else begin
            v[$urandom_range(0, NUM_DIGITS - 1)] = DIGIT_W'($urandom_range(0, 3));
        end
        return v;
    endfunction

    // Offers one item from a falling edge and returns at the falling edge after it is taken.
    task automatic send_item(input t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        tracker.take_key_vector(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        if (!quiet && send_bursts && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task automatic send_vec(t_key_vec v, bit last);
        send_item(to_item(v, last));
        sender_gap();
    endtask

    task automatic send_random_set(int len);
        t_key_vec v;
        v = '0;
        for (int i = 0; i < len; i++) begin
            v = rand_vector(v);
            send_vec(v, i == len - 1);
        end
    endtask

    // Main sequence: reset, directed sets, back-pressure, then random sets.
    initial begin : stimulus
        t_key_vec v;
        t_key_vec prefix;
        int       len;
        int       set_no;
        in_ch.valid = 1'b0;
        in_ch.item  = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-vector sets at both extremes.
        send_vec('0, 1'b1);
        send_vec('1, 1'b1);

        // Extremes of each digit, ramps and a duplicate in one set.
        send_vec('1, 1'b0);
        send_vec('0, 1'b0);
        v = '0;
        v[0] = 2'd3;
        send_vec(v, 1'b0);
        v = '0;
        v[NUM_DIGITS-1] = 2'd3;
        send_vec(v, 1'b0);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            v[i] = DIGIT_W'(i % 4);
        end
        send_vec(v, 1'b0);
        send_vec('1, 1'b0);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            v[i] = DIGIT_W'(3 - (i % 4));
        end
        send_vec(v, 1'b1);

        // Vectors sharing a long prefix, so only the low digits decide the order.
        for (int i = 0; i < NUM_DIGITS; i++) begin
            prefix[i] = DIGIT_W'($urandom_range(0, 3));
        end
        for (int k = 0; k < 8; k++) begin
            v = prefix;
            v[NUM_DIGITS-2] = DIGIT_W'($urandom_range(0, 3));
            v[NUM_DIGITS-1] = DIGIT_W'($urandom_range(0, 3));
            send_vec(v, k == 7);
        end

        // Long receiver hold-off while two sets are offered back to back.
        hold_requests++;
        send_bursts = 1'b0;
        send_random_set(12);
        send_random_set(12);

        // Random sets, with one full set and one that overflows the store.
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            send_bursts = ($urandom_range(0, 3) != 0);
            case (set_no)
                2: begin
                    len = MAX_VECTORS;
                end
                5: begin
                    len = MAX_VECTORS + 2;
                end
                default: begin
                    len = $urandom_range(1, 12);
                end
            endcase
            send_random_set(len);
            set_no++;
        end
        in_ch.valid <= 1'b0;

        // Drain the remaining results and watch for strays.
        while (!tracker.all_delivered()) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d key vectors in %0d sets, %0d of them overflowing the store.",
                 items_sent, tracker.sets_sorted, tracker.overflow_sets);
        $display("Checked %0d sorted vectors against the prediction.",
                 tracker.results_checked);
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/rsb4_pkg.sv
design/rsb4_ifs.sv
design/rsb4_ram.sv
design/rsb4_bucket.sv
design/radix_sort_base4_vectors_core.sv
dv/tb_top.sv
